// File: hdl/ps2_mouse_packet_stack_defines.svh
// Assertion macros for the PS/2 mouse packet stack checker.
`ifndef PS2_MOUSE_PACKET_STACK_DEFINES_SVH
`define PS2_MOUSE_PACKET_STACK_DEFINES_SVH

// Overlapping implication, clocked on clk, quiet while arst_n is low.
`define PS2MPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2mps check failed");

// Next-cycle implication, clocked on clk, quiet while arst_n is low.
`define PS2MPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2mps check failed");

`endif

// File: hdl/ps2mps_pkg.sv
// Shared types and constants of the PS/2 mouse packet stack.
`default_nettype none
package ps2mps_pkg;

	localparam int STACK_DEPTH = 512;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int S_TDATA_W   = 8;
	localparam int M_TDATA_W   = 24;
	localparam int SYNC_BIT    = 3;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [8:0] y_move;
		logic signed [7:0] x_move;
		logic        [2:0] buttons;
	} packet_t;

	localparam int PKT_W = $bits(packet_t);

	typedef struct packed {
		logic    valid;
		packet_t pkt;
	} push_t;

endpackage
`default_nettype wire

// File: hdl/ps2mps_parser.sv
// Byte parser: assembles three mouse bytes into one packet.
`default_nettype none
module ps2mps_parser
	import ps2mps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_en,
	input  wire logic [7:0] data_byte,
	output push_t           push
);

	typedef enum logic [1:0] {
		PH_HDR = 2'd0,
		PH_X   = 2'd1,
		PH_Y   = 2'd2
	} phase_t;

	phase_t     phase_q;
	logic [7:0] header_q;
	logic [7:0] x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			header_q <= '0;
			x_q      <= '0;
		end else if (byte_en) begin
			case (phase_q)
				PH_HDR: begin
					header_q <= data_byte;
					if (data_byte[SYNC_BIT])
						phase_q <= PH_X;
				end
				PH_X: begin
					x_q     <= data_byte;
					phase_q <= PH_Y;
				end
				PH_Y: phase_q <= PH_HDR;
				default: phase_q <= PH_HDR;
			endcase
		end
	end

	// y is the negated, sign-extended third byte
	always_comb begin
		push.valid       = byte_en && (phase_q == PH_Y);
		push.pkt.buttons = header_q[2:0];
		push.pkt.x_move  = x_q;
		push.pkt.y_move  = 9'sd0 - $signed({data_byte[7], data_byte});
	end

endmodule
`default_nettype wire

// File: hdl/ps2mps_stack.sv
// Packet LIFO: single-port memory with a fill count, registered pop data.
`default_nettype none
module ps2mps_stack
	import ps2mps_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop_en,
	output logic       found_s1,
	output packet_t    pkt_s1
);

	packet_t            mem [STACK_DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_dec;
	logic               full;
	logic               empty;

	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push.valid) begin
			if (full)
				count_q <= '0;
			else
				count_q <= count_q + CNT_W'(1);
		end else if (pop_en && !empty) begin
			count_q <= count_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && !full)
			mem[count_q[ADDR_W-1:0]] <= push.pkt;
		if (pop_en) begin
			pkt_s1   <= mem[count_dec[ADDR_W-1:0]];
			found_s1 <= !empty;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ps2_mouse_packet_stack.sv
// Top level of the PS/2 mouse packet stack.
//
// Channel | Dir | tdata (low bit up)                   | tuser
// s_*     | in  | data_byte[7:0]                       | op
// m_*     | out | buttons[2:0] x_move[10:3] y_move[19:11] | found
//
// One transaction per cycle on the input unless the output stalls; a mouse
// byte gives no result. A pop returns its result through the memory read
// register, then the output register. Reset clears parser phase, fill count
// and valid flags; memory contents are left as they are. A stalled output
// holds the result in place while a single held pop waits behind it.
`default_nettype none
module ps2_mouse_packet_stack
	import ps2mps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0]
	input  wire logic                 s_tuser,  // op
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // buttons, x_move, y_move
	output logic                      m_tuser   // found
);

	logic    accept;
	logic    byte_en;
	logic    pop_en;
	logic    advance;
	logic    valid_s1;
	logic    found_s1;
	packet_t pkt_s1;
	push_t   push;
	logic    m_valid_q;
	logic    m_found_q;
	packet_t m_pkt_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign byte_en  = accept && (s_tuser == OP_BYTE);
	assign pop_en   = accept && (s_tuser == OP_POP);

	ps2mps_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.data_byte (s_tdata[7:0]),
		.push      (push)
	);

	ps2mps_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop_en   (pop_en),
		.found_s1 (found_s1),
		.pkt_s1   (pkt_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop_en)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_found_q <= found_s1;
			m_pkt_q   <= found_s1 ? pkt_s1 : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = M_TDATA_W'(m_pkt_q);

endmodule
`default_nettype wire

// File: hdl/ps2mps_checker.sv
// Port-level checker for the PS/2 mouse packet stack, bound to the top level.
`default_nettype none
`include "ps2_mouse_packet_stack_defines.svh"
module ps2mps_checker
	import ps2mps_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 s_tuser,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tuser
);

	logic pop_acc;

	assign pop_acc = s_tvalid && s_tready && (s_tuser == OP_POP);

	`PS2MPS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`PS2MPS_ASSERT_IMP(a_empty_zero, m_tvalid && !m_tuser, m_tdata == '0)
	`PS2MPS_ASSERT_IMP(a_rise_from_pop, $rose(m_tvalid), $past(pop_acc, 2))
	`PS2MPS_ASSERT_IMP(a_ready_when_idle, !m_tvalid, s_tready)

endmodule

bind ps2_mouse_packet_stack ps2mps_checker u_ps2mps_checker (.*);
`default_nettype wire

// File: verif/tb_ps2_mouse_packet_stack.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse packet stack: directed, fill, stall and random traffic.
module tb_ps2_mouse_packet_stack
	import ps2mps_pkg::*;
();

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_X,
		PH_Y
	} parse_phase_t;

	typedef struct packed {
		logic    found;
		packet_t pkt;
	} pop_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	parse_phase_t mdl_phase  = PH_HEADER;
	logic [7:0]   mdl_header = '0;
	logic [7:0]   mdl_x      = '0;
	packet_t      mdl_stack [STACK_DEPTH];
	int           mdl_count  = 0;
	pop_result_t  pending_pops[$];

	int fail_count    = 0;
	int idle_cycles   = 0;
	bit tx_gaps_on    = 1'b0;
	bit rx_gaps_on    = 1'b0;
	bit hold_req      = 1'b0;
	bit hold_ack      = 1'b0;
	int hold_left     = 0;
	int rx_stall_left = 0;

	ps2_mouse_packet_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// mouse byte parser and packet stack
	task automatic predict_transaction(input op_t op, input logic [7:0] b);
		pop_result_t res;
		packet_t     pkt;
		res = '0;
		if (op == OP_POP) begin
			if (mdl_count > 0) begin
				mdl_count--;
				res.found = 1'b1;
				res.pkt   = mdl_stack[mdl_count];
			end
			pending_pops.push_back(res);
		end else begin
			case (mdl_phase)
				PH_HEADER: begin
					mdl_header = b;
					if (b[SYNC_BIT])
						mdl_phase = PH_X;
				end
				PH_X: begin
					mdl_x     = b;
					mdl_phase = PH_Y;
				end
				default: begin
					mdl_phase   = PH_HEADER;
					pkt.buttons = mdl_header[2:0];
					pkt.x_move  = mdl_x;
					pkt.y_move  = -$signed({b[7], b});
					// full store is flushed, new packet lost
					if (mdl_count >= STACK_DEPTH)
						mdl_count = 0;
					else begin
						mdl_stack[mdl_count] = pkt;
						mdl_count++;
					end
				end
			endcase
		end
	endtask

	task automatic send_item(input op_t op, input logic [7:0] b);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_transaction(op, b);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x, input logic [7:0] y);
		send_item(OP_BYTE, hdr);
		send_item(OP_BYTE, x);
		send_item(OP_BYTE, y);
	endtask

	task automatic send_random_packet();
		send_packet(8'($urandom_range(0, 255)) | 8'h08, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_pop();
		send_item(OP_POP, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pops.size() != 0);
	endtask

	task automatic test_directed();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		send_pop();
		send_item(OP_BYTE, 8'h07);
		send_item(OP_BYTE, 8'hF7);
		send_packet(8'h08, 8'h00, 8'h00);
		send_packet(8'hFF, 8'h7F, 8'h80);
		send_packet(8'h0D, 8'h80, 8'h7F);
		send_packet(8'h0A, 8'hFF, 8'h01);
		send_packet(8'h09, 8'h01, 8'hFF);
		repeat (6) send_pop();
		wait_drained();
	endtask

	task automatic test_fill_overflow();
		rx_gaps_on = 1'b1;
		while (mdl_count < STACK_DEPTH) begin
			tx_gaps_on = (mdl_count < STACK_DEPTH / 2);
			send_random_packet();
		end
		send_random_packet();
		send_pop();
		send_random_packet();
		send_random_packet();
		repeat (3) send_pop();
		wait_drained();
	endtask

	task automatic test_output_stall();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		repeat (4) send_random_packet();
		hold_req = ~hold_req;
		repeat (8) send_pop();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int r;
		for (int i = 0; i < 30; i++) begin
			if (i % 10 == 0) begin
				tx_gaps_on = 1'($urandom_range(0, 1));
				rx_gaps_on = 1'($urandom_range(0, 1));
			end
			r = $urandom_range(0, 99);
			if (r < 55)
				send_random_packet();
			else if (r < 85)
				send_pop();
			else
				send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
			rx_stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		pop_result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[ps2_mouse_packet_stack] ERROR");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_pops.size() == 0)
					report_mismatch($sformatf("result transaction with none pending, tdata %h",
						m_tdata));
				else begin
					want = pending_pops.pop_front();
					check_field("found", m_tuser, want.found);
					check_field("buttons", m_tdata[2:0], want.pkt.buttons);
					check_field("x_move", $signed(m_tdata[10:3]), want.pkt.x_move);
					check_field("y_move", $signed(m_tdata[19:11]), want.pkt.y_move);
					check_field("tdata pad", m_tdata[M_TDATA_W-1:PKT_W], 0);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_overflow();
		test_output_stall();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ps2_mouse_packet_stack] OK");
		else
			$display("[ps2_mouse_packet_stack] ERROR");
		$finish;
	end

endmodule

// File: ps2_mouse_packet_stack.f
+incdir+hdl
hdl/ps2mps_pkg.sv
hdl/ps2mps_parser.sv
hdl/ps2mps_stack.sv
hdl/ps2_mouse_packet_stack.sv
hdl/ps2mps_checker.sv
verif/tb_ps2_mouse_packet_stack.sv
